FILE: design/mdpp_pkg.sv
// Shared types, phase codes, status codes and field-size decoding for the packet parser.
package mdpp_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [3:0] PH_EFLAGS  = 4'd0;
  localparam logic [3:0] PH_LENF    = 4'd1;
  localparam logic [3:0] PH_PROP    = 4'd2;
  localparam logic [3:0] PH_PKT     = 4'd3;
  localparam logic [3:0] PH_SEQ     = 4'd4;
  localparam logic [3:0] PH_PAD     = 4'd5;
  localparam logic [3:0] PH_TIME    = 4'd6;
  localparam logic [3:0] PH_DUR     = 4'd7;
  localparam logic [3:0] PH_PAY1    = 4'd8;
  localparam logic [3:0] PH_WSTREAM = 4'd9;
  localparam logic [3:0] PH_WREPL   = 4'd10;
  localparam logic [3:0] PH_WLEN    = 4'd11;
  localparam logic [3:0] PH_DONE    = 4'd12;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EFLAGS   = 3'd1;
  localparam logic [2:0] ST_PROP     = 3'd2;
  localparam logic [2:0] ST_LENTYPE  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;
  localparam logic [2:0] ST_PADOVR   = 3'd6;

  localparam logic [3:0] EFLAGS_TAG   = 4'h8;
  localparam logic [1:0] LEN_TYPE_TAG = 2'b10;
  localparam logic [7:0] PROP_EXPECT  = 8'h5D;
  localparam logic [15:0] REPL_SKIP   = 16'd5;
  localparam logic [2:0] TIME_BYTES   = 3'd4;
  localparam logic [2:0] DUR_BYTES    = 3'd2;
  localparam logic [2:0] WLEN_BYTES   = 3'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] packet_length;
    logic [31:0] sequence_number;
    logic [31:0] padding_length;
    logic [31:0] send_time;
    logic [15:0] duration;
    logic [15:0] payload_size;
    logic        key_frame;
    logic        multiple_payloads;
    logic [7:0]  length_type_flags;
    logic [7:0]  property_flags;
    logic [3:0]  error_data_length;
  } result_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] nbytes;
  } enter_t;

  // Skip absent header fields starting at phase p.
  function automatic enter_t enter_target(input logic [3:0] p, input logic [7:0] lf);
    enter_t     res;
    logic [3:0] ph;
    logic       found;
    logic [1:0] code;
    logic [2:0] n;
    ph    = p;
    found = 1'b0;
    res   = '0;
    for (int i = 0; i < 5; i++) begin
      if (!found) begin
        code = 2'd0;
        n    = 3'd0;
        case (ph)
          PH_PKT, PH_SEQ, PH_PAD: begin
            if (ph == PH_PKT) begin
              code = lf[6:5];
            end else if (ph == PH_SEQ) begin
              code = lf[2:1];
            end else begin
              code = lf[4:3];
            end
            n = (code == 2'd3) ? 3'd4 : {1'b0, code};
            if (n == 3'd0) begin
              ph = ph + 4'd1;
            end else begin
              res.nbytes = n;
              found      = 1'b1;
            end
          end
          PH_TIME: begin
            res.nbytes = TIME_BYTES;
            found      = 1'b1;
          end
          PH_DUR: begin
            res.nbytes = DUR_BYTES;
            found      = 1'b1;
          end
          default: begin
            found = 1'b1;
          end
        endcase
      end
    end
    res.phase = ph;
    return res;
  endfunction

endpackage

FILE: design/mdpp_if.sv
// Handshake channels: packet byte beats in, parse results out.
interface mdpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mdpp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] packet_length;
  logic [31:0] sequence_number;
  logic [31:0] padding_length;
  logic [31:0] send_time;
  logic [15:0] duration;
  logic [15:0] payload_size;
  logic        key_frame;
  logic        multiple_payloads;
  logic [7:0]  length_type_flags;
  logic [7:0]  property_flags;
  logic [3:0]  error_data_length;
  modport source (output valid, output status, output packet_length, output sequence_number,
                  output padding_length, output send_time, output duration,
                  output payload_size, output key_frame, output multiple_payloads,
                  output length_type_flags, output property_flags,
                  output error_data_length, input ready);
  modport sink (input valid, input status, input packet_length, input sequence_number,
                input padding_length, input send_time, input duration,
                input payload_size, input key_frame, input multiple_payloads,
                input length_type_flags, input property_flags,
                input error_data_length, output ready);
endinterface

FILE: design/media_data_packet_header_parser_unit.sv
// Top level of the media data packet header parser: byte queue front end and parse back end.
//
//   channel      dir  handshake          payload
//   in_byte      in   valid/ready        data_byte[7:0], last_byte
//   out_result   out  valid/ready        status[2:0] and eleven header fields
//
// Beats stream back to back at one per clock while no result waits untaken.
// An accepted beat is held in a queue slot register until the parser takes it; the result of a
// last beat is registered when the parser takes that beat and offered from the next cycle on.
// The parser stalls only while a result waits untaken; a two-entry queue absorbs that stall.
// Synchronous active-low reset empties the queue and returns the parser to its first phase.
module media_data_packet_header_parser_unit #(
  parameter int unsigned COUNT_BITS = mdpp_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mdpp_byte_if.sink     in_byte,
  mdpp_result_if.source out_result
);
  import mdpp_pkg::*;

  beat_t q_beat;
  logic  q_valid;
  logic  q_ready;

  mdpp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .q_beat  (q_beat),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  mdpp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_beat     (q_beat),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .out_result (out_result)
  );

endmodule

FILE: design/mdpp_front.sv
// Front end: accepts byte beats into a two-entry register queue.
module mdpp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  mdpp_byte_if.sink            in_byte,
  output mdpp_pkg::beat_t      q_beat,
  output logic                 q_valid,
  input  logic                 q_ready
);
  import mdpp_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  beat_t                slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 push, pop;

  assign in_byte.ready = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign push          = in_byte.valid && in_byte.ready;
  assign q_valid       = (cnt_r != '0);
  assign pop           = q_valid && q_ready;
  assign q_beat        = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{data_byte: in_byte.data_byte, last_byte: in_byte.last_byte};
    end
  end

  queue_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

FILE: design/mdpp_back.sv
// Back end: byte-serial header parse state machine and result register.
module mdpp_back #(
  parameter int unsigned COUNT_BITS = mdpp_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mdpp_pkg::beat_t      q_beat,
  input  logic                 q_valid,
  output logic                 q_ready,
  mdpp_result_if.source        out_result
);
  import mdpp_pkg::*;

  logic [3:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] bcount_r, bcount_nxt;
  logic [2:0]            fbytes_r, fbytes_nxt;
  logic [1:0]            fidx_r, fidx_nxt;
  logic [15:0]           skip_r, skip_nxt;
  logic [7:0]            eflags_r, eflags_nxt;
  logic [7:0]            lflags_r, lflags_nxt;
  logic [7:0]            pflags_r, pflags_nxt;
  logic [31:0]           pkt_len_r, pkt_len_nxt;
  logic [31:0]           seq_r, seq_nxt;
  logic [31:0]           pad_r, pad_nxt;
  logic [31:0]           time_r, time_nxt;
  logic [15:0]           dur_r, dur_nxt;
  logic [COUNT_BITS-1:0] hdr_len_r, hdr_len_nxt;
  logic [5:0]            pay_left_r, pay_left_nxt;
  logic [COUNT_BITS-1:0] walk_r, walk_nxt;
  logic                  key_r, key_nxt;
  logic [2:0]            err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r, res_nxt;

  logic                  pop, fin;
  logic [7:0]            b;
  logic [31:0]           lane;
  logic [2:0]            fbytes_dec;
  logic                  go_enter;
  logic [3:0]            enter_from;
  enter_t                ent;
  logic                  hdr_done, pad_over;
  logic [COUNT_BITS-1:0] after;
  logic [31:0]           after32, diff32, psize32;
  logic [2:0]            status;

  assign q_ready = !out_valid_r || out_result.ready;
  assign pop     = q_valid && q_ready;
  assign fin     = pop && q_beat.last_byte;
  assign b       = q_beat.data_byte;
  assign lane    = 32'(b) << {fidx_r, 3'b000};

  always_comb begin
    phase_nxt    = phase_r;
    bcount_nxt   = bcount_r;
    fbytes_nxt   = fbytes_r;
    fidx_nxt     = fidx_r;
    skip_nxt     = skip_r;
    eflags_nxt   = eflags_r;
    lflags_nxt   = lflags_r;
    pflags_nxt   = pflags_r;
    pkt_len_nxt  = pkt_len_r;
    seq_nxt      = seq_r;
    pad_nxt      = pad_r;
    time_nxt     = time_r;
    dur_nxt      = dur_r;
    hdr_len_nxt  = hdr_len_r;
    pay_left_nxt = pay_left_r;
    walk_nxt     = walk_r;
    key_nxt      = key_r;
    err_nxt      = err_r;
    go_enter     = 1'b0;
    enter_from   = PH_PKT;
    fbytes_dec   = (fbytes_r != 3'd0) ? fbytes_r - 3'd1 : 3'd0;
    ent          = enter_target(enter_from, lflags_r);

    if (pop) begin
      if (bcount_r != '1) begin
        bcount_nxt = bcount_r + 1'b1;
      end
      case (phase_r)
        PH_EFLAGS: begin
          eflags_nxt = b;
          if (b[7:4] != EFLAGS_TAG) begin
            err_nxt   = ST_EFLAGS;
            phase_nxt = PH_DONE;
          end else begin
            skip_nxt  = 16'(b[3:0]);
            phase_nxt = PH_LENF;
          end
        end
        PH_LENF: begin
          if (skip_r != 16'd0) begin
            skip_nxt = skip_r - 16'd1;
          end else begin
            lflags_nxt = b;
            phase_nxt  = PH_PROP;
          end
        end
        PH_PROP: begin
          pflags_nxt = b;
          go_enter   = 1'b1;
          enter_from = PH_PKT;
        end
        PH_PKT, PH_SEQ, PH_PAD, PH_TIME, PH_DUR: begin
          case (phase_r)
            PH_PKT:  pkt_len_nxt = pkt_len_r | lane;
            PH_SEQ:  seq_nxt     = seq_r | lane;
            PH_PAD:  pad_nxt     = pad_r | lane;
            PH_TIME: time_nxt    = time_r | lane;
            default: dur_nxt     = dur_r | lane[15:0];
          endcase
          fidx_nxt   = fidx_r + 2'd1;
          fbytes_nxt = fbytes_dec;
          if (fbytes_dec == 3'd0) begin
            go_enter   = 1'b1;
            enter_from = phase_r + 4'd1;
          end
        end
        PH_PAY1: begin
          if (!lflags_r[0]) begin
            key_nxt   = b[7];
            phase_nxt = PH_DONE;
          end else begin
            walk_nxt = COUNT_BITS'(1);
            if (b[7:6] != LEN_TYPE_TAG) begin
              err_nxt   = ST_LENTYPE;
              phase_nxt = PH_DONE;
            end else begin
              pay_left_nxt = b[5:0];
              skip_nxt     = 16'd0;
              phase_nxt    = (b[5:0] == 6'd0) ? PH_DONE : PH_WSTREAM;
            end
          end
        end
        PH_WSTREAM: begin
          if (walk_r != '1) begin
            walk_nxt = walk_r + 1'b1;
          end
          if (skip_r != 16'd0) begin
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1 && pay_left_r == 6'd0) begin
              phase_nxt = PH_DONE;
            end
          end else begin
            if (pay_left_r != 6'd0) begin
              pay_left_nxt = pay_left_r - 6'd1;
            end
            if (b[7]) begin
              key_nxt   = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              skip_nxt  = REPL_SKIP;
              phase_nxt = PH_WREPL;
            end
          end
        end
        PH_WREPL: begin
          if (walk_r != '1) begin
            walk_nxt = walk_r + 1'b1;
          end
          if (skip_r != 16'd0) begin
            skip_nxt = skip_r - 16'd1;
          end else begin
            skip_nxt   = 16'(b);
            fbytes_nxt = WLEN_BYTES;
            phase_nxt  = PH_WLEN;
          end
        end
        PH_WLEN: begin
          if (walk_r != '1) begin
            walk_nxt = walk_r + 1'b1;
          end
          if (fbytes_r == WLEN_BYTES && skip_r != 16'd0) begin
            skip_nxt = skip_r - 16'd1;
          end else if (fbytes_r == WLEN_BYTES) begin
            skip_nxt   = 16'(b);
            fbytes_nxt = 3'd1;
          end else begin
            skip_nxt   = skip_r | {b, 8'h00};
            fbytes_nxt = 3'd0;
            phase_nxt  = (pay_left_r == 6'd0 && skip_nxt == 16'd0) ? PH_DONE : PH_WSTREAM;
          end
        end
        default: begin
        end
      endcase

      if (go_enter) begin
        ent        = enter_target(enter_from, lflags_r);
        fbytes_nxt = ent.nbytes;
        fidx_nxt   = 2'd0;
        phase_nxt  = ent.phase;
        if (ent.phase == PH_PAY1) begin
          hdr_len_nxt = bcount_nxt;
          if (lflags_r[0] && pflags_nxt != PROP_EXPECT) begin
            err_nxt   = ST_PROP;
            phase_nxt = PH_DONE;
          end
        end
      end
    end

    // Result from the state after the last beat.
    hdr_done = (phase_nxt >= PH_PAY1);
    after    = hdr_done ? bcount_nxt - hdr_len_nxt : '0;
    after32  = 32'(after);
    pad_over = hdr_done && (pad_nxt > after32);
    diff32   = after32 - pad_nxt;
    psize32  = (hdr_done && !pad_over) ? diff32 : 32'd0;
    if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (phase_nxt != PH_DONE) begin
      status = ST_TRUNC;
    end else if (pad_over) begin
      status = ST_PADOVR;
    end else if (lflags_nxt[0] && !key_nxt && 32'(walk_nxt) != psize32) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end

    res_nxt                   = res_r;
    out_valid_nxt             = out_valid_r && !out_result.ready;
    if (fin) begin
      out_valid_nxt             = 1'b1;
      res_nxt.status            = status;
      res_nxt.packet_length     = pkt_len_nxt;
      res_nxt.sequence_number   = seq_nxt;
      res_nxt.padding_length    = pad_nxt;
      res_nxt.send_time         = time_nxt;
      res_nxt.duration          = dur_nxt;
      res_nxt.payload_size      = psize32[15:0];
      res_nxt.key_frame         = key_nxt;
      res_nxt.multiple_payloads = lflags_nxt[0];
      res_nxt.length_type_flags = lflags_nxt;
      res_nxt.property_flags    = pflags_nxt;
      res_nxt.error_data_length = eflags_nxt[3:0];
      // Start the next packet from a clean state.
      phase_nxt    = PH_EFLAGS;
      bcount_nxt   = '0;
      fbytes_nxt   = 3'd0;
      fidx_nxt     = 2'd0;
      skip_nxt     = 16'd0;
      eflags_nxt   = 8'd0;
      lflags_nxt   = 8'd0;
      pflags_nxt   = 8'd0;
      pkt_len_nxt  = 32'd0;
      seq_nxt      = 32'd0;
      pad_nxt      = 32'd0;
      time_nxt     = 32'd0;
      dur_nxt      = 16'd0;
      hdr_len_nxt  = '0;
      pay_left_nxt = 6'd0;
      walk_nxt     = '0;
      key_nxt      = 1'b0;
      err_nxt      = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_EFLAGS;
      bcount_r    <= '0;
      fbytes_r    <= 3'd0;
      fidx_r      <= 2'd0;
      skip_r      <= 16'd0;
      eflags_r    <= 8'd0;
      lflags_r    <= 8'd0;
      pflags_r    <= 8'd0;
      pkt_len_r   <= 32'd0;
      seq_r       <= 32'd0;
      pad_r       <= 32'd0;
      time_r      <= 32'd0;
      dur_r       <= 16'd0;
      hdr_len_r   <= '0;
      pay_left_r  <= 6'd0;
      walk_r      <= '0;
      key_r       <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bcount_r    <= bcount_nxt;
      fbytes_r    <= fbytes_nxt;
      fidx_r      <= fidx_nxt;
      skip_r      <= skip_nxt;
      eflags_r    <= eflags_nxt;
      lflags_r    <= lflags_nxt;
      pflags_r    <= pflags_nxt;
      pkt_len_r   <= pkt_len_nxt;
      seq_r       <= seq_nxt;
      pad_r       <= pad_nxt;
      time_r      <= time_nxt;
      dur_r       <= dur_nxt;
      hdr_len_r   <= hdr_len_nxt;
      pay_left_r  <= pay_left_nxt;
      walk_r      <= walk_nxt;
      key_r       <= key_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_result.valid             = out_valid_r;
  assign out_result.status            = res_r.status;
  assign out_result.packet_length     = res_r.packet_length;
  assign out_result.sequence_number   = res_r.sequence_number;
  assign out_result.padding_length    = res_r.padding_length;
  assign out_result.send_time         = res_r.send_time;
  assign out_result.duration          = res_r.duration;
  assign out_result.payload_size      = res_r.payload_size;
  assign out_result.key_frame         = res_r.key_frame;
  assign out_result.multiple_payloads = res_r.multiple_payloads;
  assign out_result.length_type_flags = res_r.length_type_flags;
  assign out_result.property_flags    = res_r.property_flags;
  assign out_result.error_data_length = res_r.error_data_length;

  last_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("last beat produced no result");

  error_parks_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |-> (phase_r == PH_DONE))
    else $error("error recorded while still parsing");

  count_zero_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EFLAGS) == (bcount_r == '0))
    else $error("byte count out of step with phase");

  key_frame_parks_parser: assert property (@(posedge clk) disable iff (!rst_n)
    key_r |-> (phase_r == PH_DONE))
    else $error("key frame seen while still parsing");

endmodule
